// ===== rtl/core/deque_pkg.sv =====
// ----------------------------------------------------------------------------
// deque_pkg
// Shared codes and controller/datapath signal groups for the deque.
// ----------------------------------------------------------------------------
package deque_pkg;

  // fixed field widths
  localparam int OP_W     = 3;
  localparam int WORD_W   = 32;
  localparam int STATUS_W = 2;
  localparam int FILL_W   = 5;

  // operation codes
  localparam logic [OP_W-1:0] OP_PUSH_FRONT = 3'd0;
  localparam logic [OP_W-1:0] OP_PUSH_BACK  = 3'd1;
  localparam logic [OP_W-1:0] OP_POP_FRONT  = 3'd2;
  localparam logic [OP_W-1:0] OP_POP_BACK   = 3'd3;
  localparam logic [OP_W-1:0] OP_PEEK_FRONT = 3'd4;
  localparam logic [OP_W-1:0] OP_PEEK_BACK  = 3'd5;

  // status codes
  localparam logic [STATUS_W-1:0] ST_OK    = 2'd0;
  localparam logic [STATUS_W-1:0] ST_EMPTY = 2'd1;
  localparam logic [STATUS_W-1:0] ST_FULL  = 2'd2;

  // ring address select
  localparam logic [1:0] ADDR_FRONT = 2'd0; // front entry
  localparam logic [1:0] ADDR_PREV  = 2'd1; // slot ahead of front
  localparam logic [1:0] ADDR_TAIL  = 2'd2; // first free slot at back
  localparam logic [1:0] ADDR_LAST  = 2'd3; // back entry

  // controller -> datapath
  typedef struct packed {
    logic                load;       // capture transaction
    logic                mem_wr;
    logic                mem_rd;
    logic [1:0]          addr_sel;
    logic                front_dec;
    logic                front_inc;
    logic                count_inc;
    logic                count_dec;
    logic                set_result;
    logic [STATUS_W-1:0] res_status;
    logic                respond;
  } dq_cmd_t;

  // datapath -> controller
  typedef struct packed {
    logic [OP_W-1:0] op;
    logic            empty;
    logic            full;
  } dq_sts_t;

endpackage

// ===== rtl/core/deque_ctrl.sv =====
// ----------------------------------------------------------------------------
// deque_ctrl
// Sequencer: capture, execute, respond. Decodes the operation into
// datapath commands.
// ----------------------------------------------------------------------------
module deque_ctrl
  import deque_pkg::*;
(
  input  logic    clk,
  input  logic    rst_n,
  input  logic    start,
  output logic    busy,
  input  dq_sts_t sts,
  output dq_cmd_t cmd
);

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_EXEC = 2'd1;
  localparam logic [1:0] S_RESP = 2'd2;

  logic [1:0] state_r;
  logic [1:0] state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE: begin
        if (start) begin
          state_nxt = S_EXEC;
        end
      end
      S_EXEC:  state_nxt = S_RESP;
      S_RESP:  state_nxt = S_IDLE;
      default: state_nxt = S_IDLE;
    endcase
  end

  assign busy = (state_r != S_IDLE);

  always_comb begin
    cmd            = '0;
    cmd.res_status = ST_OK;
    cmd.addr_sel   = ADDR_FRONT;
    cmd.load       = (state_r == S_IDLE) && start;
    cmd.respond    = (state_r == S_RESP);
    if (state_r == S_EXEC) begin
      cmd.set_result = 1'b1;
      unique case (sts.op)
        OP_PUSH_FRONT, OP_PUSH_BACK: begin
          if (sts.full) begin
            cmd.res_status = ST_FULL;
          end else begin
            cmd.mem_wr    = 1'b1;
            cmd.count_inc = 1'b1;
            if (sts.op == OP_PUSH_FRONT) begin
              cmd.addr_sel  = ADDR_PREV;
              cmd.front_dec = 1'b1;
            end else begin
              cmd.addr_sel = ADDR_TAIL;
            end
          end
        end
        OP_POP_FRONT, OP_POP_BACK, OP_PEEK_FRONT, OP_PEEK_BACK: begin
          if (sts.empty) begin
            cmd.res_status = ST_EMPTY;
          end else begin
            cmd.mem_rd = 1'b1;
            if (sts.op == OP_POP_BACK || sts.op == OP_PEEK_BACK) begin
              cmd.addr_sel = ADDR_LAST;
            end
            if (sts.op == OP_POP_FRONT) begin
              cmd.front_inc = 1'b1;
              cmd.count_dec = 1'b1;
            end
            if (sts.op == OP_POP_BACK) begin
              cmd.count_dec = 1'b1;
            end
          end
        end
        default: cmd.res_status = ST_OK; // unused codes: no change
      endcase
    end
  end

endmodule

// ===== rtl/core/deque_dp.sv =====
// ----------------------------------------------------------------------------
// deque_dp
// Ring storage, front index, entry count and result registers.
// ----------------------------------------------------------------------------
module deque_dp
  import deque_pkg::*;
#(
  parameter int DEPTH      = 16,
  parameter int DATA_WIDTH = 32
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  dq_cmd_t                    cmd,
  output dq_sts_t                    sts,
  input  logic [OP_W-1:0]            in_operation,
  input  logic signed [WORD_W-1:0]   in_data_in,
  output logic signed [WORD_W-1:0]   out_data_out,
  output logic [STATUS_W-1:0]        out_status,
  output logic                       out_is_empty,
  output logic [FILL_W-1:0]          out_fill_count
);

  localparam int AW = $clog2(DEPTH);
  localparam int CW = $clog2(DEPTH + 1);
  localparam int SW = AW + 1;

  logic [DATA_WIDTH-1:0] mem [DEPTH];

  logic [OP_W-1:0]       op_r;
  logic [DATA_WIDTH-1:0] word_r;
  logic [AW-1:0]         front_r;
  logic [AW-1:0]         front_nxt;
  logic [CW-1:0]         count_r;
  logic [CW-1:0]         count_nxt;
  logic [DATA_WIDTH-1:0] rd_data_r;
  logic [STATUS_W-1:0]   status_r;
  logic                  use_mem_r;

  logic [SW-1:0] tail_sum;
  logic [SW-1:0] last_sum;
  logic [AW-1:0] tail_idx;
  logic [AW-1:0] last_idx;
  logic [AW-1:0] prev_idx;
  logic [AW-1:0] next_idx;
  logic [AW-1:0] addr;

  // ring arithmetic: sums stay below twice the depth, one subtract wraps
  always_comb begin
    tail_sum = SW'(front_r) + SW'(count_r);
    last_sum = tail_sum - SW'(1);
    tail_idx = (tail_sum >= SW'(DEPTH)) ? AW'(tail_sum - SW'(DEPTH)) : AW'(tail_sum);
    last_idx = (last_sum >= SW'(DEPTH)) ? AW'(last_sum - SW'(DEPTH)) : AW'(last_sum);
    prev_idx = (front_r == '0) ? AW'(DEPTH - 1) : front_r - AW'(1);
    next_idx = (front_r == AW'(DEPTH - 1)) ? '0 : front_r + AW'(1);
  end

  always_comb begin
    unique case (cmd.addr_sel)
      ADDR_FRONT: addr = front_r;
      ADDR_PREV:  addr = prev_idx;
      ADDR_TAIL:  addr = tail_idx;
      ADDR_LAST:  addr = last_idx;
      default:    addr = front_r;
    endcase
  end

  always_comb begin
    front_nxt = front_r;
    count_nxt = count_r;
    if (cmd.front_dec) begin
      front_nxt = prev_idx;
    end else if (cmd.front_inc) begin
      front_nxt = next_idx;
    end
    if (cmd.count_inc) begin
      count_nxt = count_r + CW'(1);
    end else if (cmd.count_dec) begin
      count_nxt = count_r - CW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      front_r <= '0;
      count_r <= '0;
    end else begin
      front_r <= front_nxt;
      count_r <= count_nxt;
    end
  end

  // transaction capture and result registers
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      op_r   <= in_operation;
      word_r <= DATA_WIDTH'(in_data_in);
    end
    if (cmd.set_result) begin
      status_r  <= cmd.res_status;
      use_mem_r <= cmd.mem_rd;
    end
  end

  // ring memory, registered read
  always_ff @(posedge clk) begin
    if (cmd.mem_wr) begin
      mem[addr] <= word_r;
    end
    if (cmd.mem_rd) begin
      rd_data_r <= mem[addr];
    end
  end

  assign sts.op    = op_r;
  assign sts.empty = (count_r == '0);
  assign sts.full  = (count_r == CW'(DEPTH));

  logic signed [DATA_WIDTH-1:0] rd_signed;
  assign rd_signed = rd_data_r;

  always_comb begin
    if (use_mem_r) begin
      out_data_out = WORD_W'(rd_signed);
    end else if (status_r == ST_EMPTY) begin
      out_data_out = -32'sd1;
    end else begin
      out_data_out = '0;
    end
  end

  assign out_status     = status_r;
  assign out_is_empty   = (count_r == '0);
  assign out_fill_count = FILL_W'(count_r);

endmodule

// ===== rtl/core/double_ended_queue.sv =====
// ----------------------------------------------------------------------------
// double_ended_queue
// Bounded double-ended queue of signed words held in a ring buffer, with
// push/pop/peek at either end and a status result per transaction.
// ----------------------------------------------------------------------------
//
//  channel | ports                                              | handshake
//  --------+----------------------------------------------------+-----------------
//  input   | in_operation, in_data_in                           | start & !busy
//  result  | out_data_out, out_status, out_is_empty,            | out_valid strobe,
//          | out_fill_count                                     | one cycle
//
//  Each transaction runs capture, execute (one ring memory access plus
//  index and count update) and respond, in that order. The single memory
//  port and its registered read set these steps; busy is high during
//  execute and respond. A new start is taken in the cycle after the out_valid strobe.
//  Reset (rst_n low, synchronous) empties the queue: front index and count
//  go to zero. Ring contents are not cleared; only written entries are read.
//  The receiver cannot stall: each result is presented for one cycle only.
//
module double_ended_queue
  import deque_pkg::*;
#(
  parameter int DEPTH      = 16,
  parameter int DATA_WIDTH = 32
) (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     start,
  output logic                     busy,
  input  logic [OP_W-1:0]          in_operation,
  input  logic signed [WORD_W-1:0] in_data_in,
  output logic                     out_valid,
  output logic signed [WORD_W-1:0] out_data_out,
  output logic [STATUS_W-1:0]      out_status,
  output logic                     out_is_empty,
  output logic [FILL_W-1:0]        out_fill_count
);

  dq_cmd_t cmd;
  dq_sts_t sts;

  // controller: sequences each transaction and decodes the operation
  deque_ctrl u_ctrl (
    .clk   (clk),
    .rst_n (rst_n),
    .start (start),
    .busy  (busy),
    .sts   (sts),
    .cmd   (cmd)
  );

  // datapath: ring memory, front index, count, result registers
  deque_dp #(
    .DEPTH      (DEPTH),
    .DATA_WIDTH (DATA_WIDTH)
  ) u_dp (
    .clk            (clk),
    .rst_n          (rst_n),
    .cmd            (cmd),
    .sts            (sts),
    .in_operation   (in_operation),
    .in_data_in     (in_data_in),
    .out_data_out   (out_data_out),
    .out_status     (out_status),
    .out_is_empty   (out_is_empty),
    .out_fill_count (out_fill_count)
  );

  // result strobe comes straight from the respond state
  assign out_valid = cmd.respond;

endmodule
